// ===== hdl/bb3_pkg.sv =====
// ----------------------------------------------------------------------------
// bb3_pkg
// Shared types and constants of the 3x3 RGB box blur.
// ----------------------------------------------------------------------------
package bb3_pkg;

  localparam int CHAN_W      = 8;
  localparam int POS_W       = 10;
  localparam int CFG_DATA_W  = 11;
  localparam int CFG_IDX_W   = 1;
  localparam int SUM_W       = 12;
  localparam int RECIP_W     = 13;
  localparam int RECIP_SHIFT = 16;

  // floor(s / 9) == (s * RECIP) >> RECIP_SHIFT for every 9-tap sum of bytes
  localparam logic [RECIP_W-1:0] RECIP = 13'd7282;

  localparam logic [CHAN_W-1:0]     ALPHA_FULL      = 8'hFF;
  localparam logic [CFG_DATA_W-1:0] WIDTH_RST       = 11'd640;
  localparam logic [CFG_DATA_W-1:0] HEIGHT_RST      = 11'd480;
  localparam int                    DIM_MIN         = 3;
  localparam int                    MAX_WIDTH_DEF   = 1024;
  localparam int                    MAX_HEIGHT_DEF  = 1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_t;

  // up, middle, current row
  typedef pixel_t [2:0] column_t;

  typedef struct packed {
    pixel_t           pix;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic             last;
  } result_t;

endpackage

// ===== hdl/bb3_if.sv =====
// ----------------------------------------------------------------------------
// bb3 channel interfaces
// Pixel input, result output and register write channels (valid/ready).
// ----------------------------------------------------------------------------
interface bb3_pix_in_if;
  import bb3_pkg::*;

  logic              valid;
  logic              ready;
  logic              action;
  logic [CHAN_W-1:0] in_red;
  logic [CHAN_W-1:0] in_green;
  logic [CHAN_W-1:0] in_blue;

  modport source (output valid, action, in_red, in_green, in_blue, input ready);
  modport sink   (input valid, action, in_red, in_green, in_blue, output ready);
endinterface

interface bb3_pix_out_if;
  import bb3_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] out_red;
  logic [CHAN_W-1:0] out_green;
  logic [CHAN_W-1:0] out_blue;
  logic [CHAN_W-1:0] out_alpha;
  logic [POS_W-1:0]  out_x;
  logic [POS_W-1:0]  out_y;
  logic              last_of_run;

  modport source (output valid, out_red, out_green, out_blue, out_alpha, out_x, out_y,
                  last_of_run, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, out_alpha, out_x, out_y,
                  last_of_run, output ready);
endinterface

interface bb3_cfg_if;
  import bb3_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/bb3_ram.sv =====
// ----------------------------------------------------------------------------
// bb3_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bb3_ram #(
  parameter int Width = 24,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/bb3_kernel.sv =====
// ----------------------------------------------------------------------------
// bb3_kernel
// 3x3 per-channel sum and divide by nine (reciprocal multiply, truncating).
// ----------------------------------------------------------------------------
module bb3_kernel (
  input  bb3_pkg::pixel_t [8:0] taps_i,
  output bb3_pkg::pixel_t       avg_o
);
  import bb3_pkg::*;

  localparam int PROD_W = SUM_W + RECIP_W;

  logic [SUM_W-1:0]  sum_r, sum_g, sum_b;
  logic [PROD_W-1:0] prod_r, prod_g, prod_b;

  always_comb begin
    sum_r = '0;
    sum_g = '0;
    sum_b = '0;
    for (int i = 0; i < 9; i++) begin
      sum_r = sum_r + SUM_W'(taps_i[i].red);
      sum_g = sum_g + SUM_W'(taps_i[i].green);
      sum_b = sum_b + SUM_W'(taps_i[i].blue);
    end
    prod_r = PROD_W'(sum_r) * PROD_W'(RECIP);
    prod_g = PROD_W'(sum_g) * PROD_W'(RECIP);
    prod_b = PROD_W'(sum_b) * PROD_W'(RECIP);
    avg_o.red   = prod_r[RECIP_SHIFT +: CHAN_W];
    avg_o.green = prod_g[RECIP_SHIFT +: CHAN_W];
    avg_o.blue  = prod_b[RECIP_SHIFT +: CHAN_W];
  end

endmodule

// ===== hdl/box_blur_3x3_rgb.sv =====
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb
// Streaming 3x3 box blur over raster-order RGB pixels, alpha forced to 0xFF.
// ----------------------------------------------------------------------------
// Stage 1 registers each pixel, then the result queue registers its results.
// Throughput: one input transaction per cycle while the queue has room;
//   the line-store RAMs take one read and one write per cycle. A row-end
//   pixel past row 0 yields two results, which leave through the output
//   port at one per cycle while the sink is ready.
// Reset: counters, window, result queue and frame size registers are cleared
//   or preset at once; the line stores are not cleared and need no pass.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb #(
  parameter int MAX_WIDTH  = bb3_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bb3_pkg::MAX_HEIGHT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bb3_pix_in_if.sink  pix_i,
  bb3_pix_out_if.source pix_o,
  bb3_cfg_if.sink     cfg_i
);
  import bb3_pkg::*;

  localparam int XW   = $clog2(MAX_WIDTH);
  localparam int YW   = $clog2(MAX_HEIGHT + 1);
  localparam int WW   = XW + 1;
  localparam int CmpW = (WW > CFG_DATA_W) ? WW + 1 :
                        ((YW > CFG_DATA_W) ? YW + 1 : CFG_DATA_W + 1);

  // ---------------- configuration ----------------
  logic [CFG_DATA_W-1:0] width_q, height_q;
  logic                  cfg_wr;
  logic [CmpW-1:0]       w_ext, h_ext, w_clamp, h_clamp;
  logic [WW-1:0]         w_eff;
  logic [YW-1:0]         h_eff;

  assign cfg_i.ready = 1'b1;
  assign cfg_wr      = cfg_i.valid & cfg_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (cfg_wr) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_FRAME_WIDTH:  width_q  <= cfg_i.data;
        REG_FRAME_HEIGHT: height_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    w_ext = CmpW'(width_q);
    h_ext = CmpW'(height_q);
    if (w_ext < CmpW'(DIM_MIN)) begin
      w_clamp = CmpW'(DIM_MIN);
    end else if (w_ext > CmpW'(MAX_WIDTH)) begin
      w_clamp = CmpW'(MAX_WIDTH);
    end else begin
      w_clamp = w_ext;
    end
    if (h_ext < CmpW'(DIM_MIN)) begin
      h_clamp = CmpW'(DIM_MIN);
    end else if (h_ext > CmpW'(MAX_HEIGHT)) begin
      h_clamp = CmpW'(MAX_HEIGHT);
    end else begin
      h_clamp = h_ext;
    end
    w_eff = WW'(w_clamp);
    h_eff = YW'(h_clamp);
  end

  // ---------------- input side: position counters ----------------
  logic          in_acc;
  logic [XW-1:0] col_q, col_d;
  logic [YW-1:0] row_q, row_d;
  logic [WW-1:0] col_inc;
  logic          at_last_col;
  pixel_t        in_px;

  assign in_acc      = pix_i.valid & pix_i.ready;
  assign col_inc     = WW'(col_q) + WW'(1);
  assign at_last_col = (col_inc >= w_eff);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (at_last_col) begin
      col_d = '0;
      row_d = (row_q == h_eff) ? '0 : row_q + YW'(1);
    end else begin
      col_d = XW'(col_inc);
    end
    if (pix_i.action || row_q == h_eff) begin
      in_px = '0;
    end else begin
      in_px.red   = pix_i.in_red;
      in_px.green = pix_i.in_green;
      in_px.blue  = pix_i.in_blue;
    end
  end

  // ---------------- stage 1: item with line-store data ----------------
  logic          s1_v_q;
  logic [XW-1:0] s1_x_q;
  logic [YW-1:0] s1_y_q;
  pixel_t        s1_px_q;
  logic          s1_lastcol_q;
  logic          s1_fire;
  pixel_t        up_rd, mid_rd, up_m, mid_m;
  column_t       cur_col;
  column_t       win_q [2];

  bb3_ram #(.Width($bits(pixel_t)), .Depth(MAX_WIDTH)) u_line_upper (
    .clk_i   (clk_i),
    .we_i    (s1_fire),
    .waddr_i (s1_x_q),
    .wdata_i (mid_m),
    .re_i    (in_acc),
    .raddr_i (col_q),
    .rdata_o (up_rd)
  );

  bb3_ram #(.Width($bits(pixel_t)), .Depth(MAX_WIDTH)) u_line_middle (
    .clk_i   (clk_i),
    .we_i    (s1_fire),
    .waddr_i (s1_x_q),
    .wdata_i (s1_px_q),
    .re_i    (in_acc),
    .raddr_i (col_q),
    .rdata_o (mid_rd)
  );

  assign up_m    = (s1_y_q > YW'(1)) ? up_rd : '0;
  assign mid_m   = (s1_y_q != '0) ? mid_rd : '0;
  assign cur_col = {s1_px_q, mid_m, up_m};

  // ---------------- result computation ----------------
  pixel_t [8:0] taps_a, taps_b;
  pixel_t       avg_a, avg_b;
  result_t      res_a, res_b;
  logic         s1_emit;
  logic [1:0]   s1_n;

  assign taps_a = {cur_col, win_q[1], win_q[0]};
  assign taps_b = {column_t'('0), cur_col, win_q[1]};

  bb3_kernel u_kernel_a (.taps_i(taps_a), .avg_o(avg_a));
  bb3_kernel u_kernel_b (.taps_i(taps_b), .avg_o(avg_b));

  assign s1_emit = (s1_y_q != '0) && (s1_x_q != '0);
  assign s1_n    = !s1_emit ? 2'd0 : (s1_lastcol_q ? 2'd2 : 2'd1);

  always_comb begin
    res_a.pix  = avg_a;
    res_a.x    = POS_W'(s1_x_q - XW'(1));
    res_a.y    = POS_W'(s1_y_q - YW'(1));
    res_a.last = ~s1_lastcol_q;
    res_b.pix  = avg_b;
    res_b.x    = POS_W'(s1_x_q);
    res_b.y    = POS_W'(s1_y_q - YW'(1));
    res_b.last = 1'b1;
  end

  // ---------------- two-entry result queue ----------------
  result_t    q_q [2];
  result_t    q_d [2];
  logic [1:0] cnt_q, cnt_d, base;
  logic       pop;

  assign pop     = pix_o.valid & pix_o.ready;
  assign base    = cnt_q - {1'b0, pop};
  assign s1_fire = s1_v_q && (s1_n <= (2'd2 - base));

  assign pix_i.ready = ~s1_v_q | s1_fire;

  always_comb begin
    q_d[0] = q_q[0];
    q_d[1] = q_q[1];
    cnt_d  = base;
    if (pop) begin
      q_d[0] = q_q[1];
    end
    if (s1_fire) begin
      cnt_d = base + s1_n;
      if (s1_n != 2'd0) begin
        if (base == 2'd0) begin
          q_d[0] = res_a;
        end else begin
          q_d[1] = res_a;
        end
      end
      if (s1_n == 2'd2) begin
        q_d[1] = res_b;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    q_q[0] <= q_d[0];
    q_q[1] <= q_d[1];
  end

  // ---------------- control and window registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      s1_v_q   <= 1'b0;
      cnt_q    <= '0;
      win_q[0] <= '0;
      win_q[1] <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (in_acc) begin
        s1_v_q <= 1'b1;
      end else if (s1_fire) begin
        s1_v_q <= 1'b0;
      end
      if (cfg_wr) begin
        col_q    <= '0;
        row_q    <= '0;
        win_q[0] <= '0;
        win_q[1] <= '0;
      end else begin
        if (in_acc) begin
          col_q <= col_d;
          row_q <= row_d;
        end
        if (s1_fire) begin
          win_q[0] <= (s1_x_q == '0) ? column_t'('0) : win_q[1];
          win_q[1] <= cur_col;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_x_q       <= col_q;
      s1_y_q       <= row_q;
      s1_px_q      <= in_px;
      s1_lastcol_q <= at_last_col;
    end
  end

  // ---------------- output port ----------------
  assign pix_o.valid       = (cnt_q != 2'd0);
  assign pix_o.out_red     = q_q[0].pix.red;
  assign pix_o.out_green   = q_q[0].pix.green;
  assign pix_o.out_blue    = q_q[0].pix.blue;
  assign pix_o.out_alpha   = ALPHA_FULL;
  assign pix_o.out_x       = q_q[0].x;
  assign pix_o.out_y       = q_q[0].y;
  assign pix_o.last_of_run = q_q[0].last;

endmodule

// ===== tb/box_blur_3x3_rgb_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb_tb
// Self-checking bench for the streaming 3x3 RGB box blur. A directed table
// (white frame with edge and corner sums, flush row, zero items inside the
// frame) runs first, then frames of fixed and random size with random
// content, including sizes below the minimum, and partial frames. Every
// result is checked in order against an in-bench model of the line stores,
// the window and the frame counters.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb_tb;
  import bb3_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_WAIT  = 8;
  localparam int SQUEEZE_LEN = 300;
  localparam int RAND_TARGET = 930;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
    logic              last;
  } blur_px_t;

  typedef struct {
    bit                    is_cfg;
    cfg_reg_e              cfg_reg;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  act;
    pixel_t                pix;
    int                    lvl_first;
    int                    lvl_second;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  bb3_pix_in_if  pin ();
  bb3_pix_out_if pout ();
  bb3_cfg_if     cfg ();

  box_blur_3x3_rgb dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .pix_i  (pin),
    .pix_o  (pout),
    .cfg_i  (cfg)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // blur model state
  logic [CFG_DATA_W-1:0] width_reg;
  logic [CFG_DATA_W-1:0] height_reg;
  pixel_t                line_up  [MAX_WIDTH_DEF];
  pixel_t                line_mid [MAX_WIDTH_DEF];
  column_t               win_old;
  column_t               win_new;
  int unsigned           col_cnt;
  int unsigned           row_cnt;

  blur_px_t blur_q [$];
  int       mismatches = 0;
  int       sink_hold  = 0;
  bit       sink_burst = 1'b0;
  int       rand_items = 0;
  int       idle_run   = 0;

  // white 3x3 frame: corner 4*255/9, edge 6*255/9, center 255
  stim_row_t dir_tab [23] = '{
    '{1'b1, REG_FRAME_WIDTH,  11'd0, 1'b0, 24'h000000,  -1,  -1},
    '{1'b1, REG_FRAME_HEIGHT, 11'd1, 1'b0, 24'h000000,  -1,  -1},
    '{1'b0, REG_FRAME_WIDTH,  11'd0, 1'b0, 24'hFFFFFF,  -1,  -1},
    '{1'b0, REG_FRAME_WIDTH,  11'd0, 1'b0, 24'hFFFFFF,  -1,  -1},
    '{1'b0, REG_FRAME_WIDTH,  11'd0, 1'b0, 24'hFFFFFF,  -1,  -1},
    '{1'b0, REG_FRAME_WIDTH,  11'd0, 1'b0, 24'hFFFFFF,  -1,  -1},
    '{1'b0, REG_FRAME_WIDTH,  11'd0, 1'b0, 24'hFFFFFF, 113,  -1},
    '{1'b0, REG_FRAME_WIDTH,  11'd0, 1'b0, 24'hFFFFFF, 170, 113},
    '{1'b0, REG_FRAME_WIDTH,  11'd0, 1'b0, 24'hFFFFFF,  -1,  -1},
    '{1'b0, REG_FRAME_WIDTH,  11'd0, 1'b0, 24'hFFFFFF, 170,  -1},
    '{1'b0, REG_FRAME_WIDTH,  11'd0, 1'b0, 24'hFFFFFF, 255, 170},
    '{1'b0, REG_FRAME_WIDTH,  11'd0, 1'b0, 24'hFFFFFF,  -1,  -1},
    '{1'b0, REG_FRAME_WIDTH,  11'd0, 1'b1, 24'hFFFFFF, 113,  -1},
    '{1'b0, REG_FRAME_WIDTH,  11'd0, 1'b0, 24'hFFFFFF, 170, 113},
    '{1'b0, REG_FRAME_WIDTH,  11'd0, 1'b0, 24'h000000,  -1,  -1},
    '{1'b0, REG_FRAME_WIDTH,  11'd0, 1'b1, 24'hFFFFFF,  -1,  -1},
    '{1'b0, REG_FRAME_WIDTH,  11'd0, 1'b0, 24'hFF00FF,  -1,  -1},
    '{1'b0, REG_FRAME_WIDTH,  11'd0, 1'b0, 24'h0180FE,  -1,  -1},
    '{1'b0, REG_FRAME_WIDTH,  11'd0, 1'b1, 24'h123456,  -1,  -1},
    '{1'b0, REG_FRAME_WIDTH,  11'd0, 1'b0, 24'hAA550F,  -1,  -1},
    '{1'b0, REG_FRAME_WIDTH,  11'd0, 1'b0, 24'h7F8001,  -1,  -1},
    '{1'b0, REG_FRAME_WIDTH,  11'd0, 1'b0, 24'hFFFFFF,  -1,  -1},
    '{1'b0, REG_FRAME_WIDTH,  11'd0, 1'b0, 24'h000000,  -1,  -1}
  };

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v < DIM_MIN) return DIM_MIN;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic blur_px_t average_window(column_t a, column_t b, column_t c,
                                              int unsigned x, int unsigned y, bit last);
    blur_px_t    r;
    int unsigned sr, sg, sb;
    sr = 0;
    sg = 0;
    sb = 0;
    for (int k = 0; k < 3; k++) begin
      sr = sr + a[k].red   + b[k].red   + c[k].red;
      sg = sg + a[k].green + b[k].green + c[k].green;
      sb = sb + a[k].blue  + b[k].blue  + c[k].blue;
    end
    r.red   = CHAN_W'(sr / 9);
    r.green = CHAN_W'(sg / 9);
    r.blue  = CHAN_W'(sb / 9);
    r.alpha = ALPHA_FULL;
    r.x     = POS_W'(x);
    r.y     = POS_W'(y);
    r.last  = last;
    return r;
  endfunction

  function automatic void restart_frame();
    win_old = '0;
    win_new = '0;
    col_cnt = 0;
    row_cnt = 0;
  endfunction

  function automatic void blur_pixel(logic act, pixel_t pix, output int n_res);
    int unsigned w, h, x, y;
    pixel_t      px;
    column_t     cur;
    w = clamp_dim(width_reg, MAX_WIDTH_DEF);
    h = clamp_dim(height_reg, MAX_HEIGHT_DEF);
    x = col_cnt;
    y = row_cnt;
    n_res = 0;
    if (x >= w) x = w - 1;
    if (y > h) y = h;
    px = (act || y == h) ? '0 : pix;
    cur[0] = (y >= 2) ? line_up[x] : '0;
    cur[1] = (y >= 1) ? line_mid[x] : '0;
    cur[2] = px;
    line_up[x]  = cur[1];
    line_mid[x] = px;
    if (x == 0) begin
      win_old = '0;
      win_new = '0;
    end
    if (y >= 1 && x >= 1) begin
      blur_q.push_back(average_window(win_old, win_new, cur, x - 1, y - 1, x != w - 1));
      n_res = 1;
      if (x == w - 1) begin
        blur_q.push_back(average_window(win_new, cur, '0, x, y - 1, 1'b1));
        n_res = 2;
      end
    end
    win_old = win_new;
    win_new = cur;
    x++;
    if (x >= w) begin
      x = 0;
      y++;
      if (y > h) y = 0;
    end
    col_cnt = x;
    row_cnt = y;
  endfunction

  function automatic logic [CHAN_W-1:0] rand_chan();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return CHAN_W'($urandom);
    endcase
  endfunction

  task automatic push_pixel(input logic act, input pixel_t pix, input bit no_gap,
                            output int n_res);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      pin.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pin.valid    <= 1'b1;
    pin.action   <= act;
    pin.in_red   <= pix.red;
    pin.in_green <= pix.green;
    pin.in_blue  <= pix.blue;
    do @(posedge clk); while (pin.ready !== 1'b1);
    blur_pixel(act, pix, n_res);
  endtask

  // always waits on the clock before raising, so back-to-back writes stay clean
  task automatic cfg_write(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    repeat ($urandom_range(1, 19)) @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk); while (cfg.ready !== 1'b1);
    cfg.valid <= 1'b0;
    case (idx)
      REG_FRAME_WIDTH:  width_reg = val;
      REG_FRAME_HEIGHT: height_reg = val;
      default: ;
    endcase
    restart_frame();
  endtask

  task automatic wait_drained();
    pin.valid <= 1'b0;
    while (blur_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic run_phase(input logic [CFG_DATA_W-1:0] w_dat, h_dat, input int n_items,
                           input bit burst, input int squeeze_at, input int pause_at,
                           input bit counted);
    int burst_left;
    int n_res;
    burst_left = 0;
    wait_drained();
    cfg_write(REG_FRAME_WIDTH, w_dat);
    cfg_write(REG_FRAME_HEIGHT, h_dat);
    sink_burst = burst;
    for (int i = 0; i < n_items; i++) begin
      if (i == pause_at) wait_drained();
      if (i == squeeze_at) begin
        sink_hold  = SQUEEZE_LEN;
        burst_left = 40;
      end
      push_pixel($urandom_range(0, 11) == 0, {rand_chan(), rand_chan(), rand_chan()},
                 burst || burst_left > 0, n_res);
      if (burst_left > 0) burst_left--;
      if (counted) rand_items++;
    end
    sink_burst = 1'b0;
  endtask

  // result sink: random stalls, long hold-off on request
  initial begin : sink
    int       wait_n;
    blur_px_t got;
    blur_px_t want;
    pout.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      wait_n = sink_burst ? 0 : $urandom_range(0, 19);
      if (sink_hold > 0) begin
        wait_n    = sink_hold;
        sink_hold = 0;
      end
      if (wait_n > 0) begin
        pout.ready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      pout.ready <= 1'b1;
      do @(posedge clk); while (pout.valid !== 1'b1);
      got = '{pout.out_red, pout.out_green, pout.out_blue, pout.out_alpha,
              pout.out_x, pout.out_y, pout.last_of_run};
      if (blur_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result x%0d y%0d rgb %h %h %h", got.x, got.y,
                   got.red, got.green, got.blue);
      end else begin
        want = blur_q.pop_front();
        if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
            got.alpha !== want.alpha || got.x !== want.x || got.y !== want.y ||
            got.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: exp x%0d y%0d rgba %h %h %h %h last %b",
                     want.x, want.y, want.red, want.green, want.blue, want.alpha,
                     want.last);
            $display("          got x%0d y%0d rgba %h %h %h %h last %b",
                     got.x, got.y, got.red, got.green, got.blue, got.alpha, got.last);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((pin.valid && pin.ready) || (pout.valid && pout.ready) || (cfg.valid && cfg.ready))
      idle_run <= 0;
    else
      idle_run <= idle_run + 1;
    if (idle_run >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : stimulus
    int n_res;
    int w, h, full, n;
    rst_n        = 1'b0;
    pin.valid    <= 1'b0;
    pin.action   <= 1'b0;
    pin.in_red   <= '0;
    pin.in_green <= '0;
    pin.in_blue  <= '0;
    cfg.valid    <= 1'b0;
    cfg.index    <= REG_FRAME_WIDTH;
    cfg.data     <= '0;
    width_reg  = WIDTH_RST;
    height_reg = HEIGHT_RST;
    foreach (line_up[i]) begin
      line_up[i]  = '0;
      line_mid[i] = '0;
    end
    restart_frame();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        wait_drained();
        cfg_write(dir_tab[i].cfg_reg, dir_tab[i].cfg_data);
      end else begin
        push_pixel(dir_tab[i].act, dir_tab[i].pix, 1'b0, n_res);
        if (dir_tab[i].lvl_first >= 0) begin
          blur_q[blur_q.size() - n_res].red   = CHAN_W'(dir_tab[i].lvl_first);
          blur_q[blur_q.size() - n_res].green = CHAN_W'(dir_tab[i].lvl_first);
          blur_q[blur_q.size() - n_res].blue  = CHAN_W'(dir_tab[i].lvl_first);
        end
        if (dir_tab[i].lvl_second >= 0) begin
          blur_q[blur_q.size() - 1].red   = CHAN_W'(dir_tab[i].lvl_second);
          blur_q[blur_q.size() - 1].green = CHAN_W'(dir_tab[i].lvl_second);
          blur_q[blur_q.size() - 1].blue  = CHAN_W'(dir_tab[i].lvl_second);
        end
      end
    end

    run_phase(11'd5, 11'd4, 75, 1'b0, -1, 30, 1'b1);
    run_phase(11'd3, 11'd3, 48, 1'b0, 14, -1, 1'b1);
    run_phase(WIDTH_RST, HEIGHT_RST, 645, 1'b0, -1, -1, 1'b1);

    while (rand_items < RAND_TARGET) begin
      w    = $urandom_range(0, 12);
      h    = $urandom_range(0, 9);
      full = clamp_dim(w, MAX_WIDTH_DEF) * (clamp_dim(h, MAX_HEIGHT_DEF) + 1);
      n    = full * $urandom_range(1, 3);
      if ($urandom_range(0, 3) == 0) n = $urandom_range(1, n);
      if (n > RAND_TARGET - rand_items) n = RAND_TARGET - rand_items;
      run_phase(CFG_DATA_W'(w), CFG_DATA_W'(h), n, $urandom_range(0, 5) == 0, -1,
                ($urandom_range(0, 3) == 0) ? $urandom_range(0, n - 1) : -1, 1'b1);
    end

    wait_drained();
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
